FILE: rtl/pixel_histogram_assert.svh
// Assertion macros used by the pixel histogram checker.
`ifndef PIXEL_HISTOGRAM_ASSERT_SVH
`define PIXEL_HISTOGRAM_ASSERT_SVH

// same-cycle implication
`define PH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ph_pkg.sv
// Types, constants and helpers of the pixel histogram.
package ph_pkg;

	localparam int BIN_COUNT   = 256;
	localparam int COUNT_BITS  = 24;
	localparam int OP_W        = 2;
	localparam int VALUE_W     = 8;
	localparam int OUT_W       = 24;
	localparam int BIN_W       = $clog2(BIN_COUNT);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [63:0]           OUT_MAX   = (64'd1 << OUT_W) - 64'd1;

	typedef enum logic [OP_W-1:0] {
		OP_COUNT      = 2'd0,
		OP_READ       = 2'd1,
		OP_READ_CLEAR = 2'd2
	} ph_op_t;

	typedef enum logic {
		BK_IDLE,
		BK_APPLY
	} ph_bk_state_t;

	typedef struct packed {
		ph_op_t             op;
		logic [VALUE_W-1:0] value;
		logic               in_range;
		logic [BIN_W-1:0]   addr;
	} ph_item_t;

	function automatic logic [OUT_W-1:0] ph_out_sat(input logic [COUNT_BITS-1:0] cnt);
		logic [63:0] wide;
		wide = 64'(cnt);
		if (wide > OUT_MAX) begin
			wide = OUT_MAX;
		end
		return OUT_W'(wide);
	endfunction

endpackage

FILE: rtl/ph_if.sv
// Valid/ready channel interfaces for histogram items and results.
interface ph_in_if import ph_pkg::*;;
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    opcode;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface ph_out_if import ph_pkg::*;;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] bin_index;
	logic [OUT_W-1:0]   bin_count;

	modport source (output valid, output bin_index, output bin_count, input ready);
	modport sink   (input valid, input bin_index, input bin_count, output ready);
endinterface

FILE: rtl/ph_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
module ph_front import ph_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ph_in_if.sink       item,
	output ph_item_t    q_head,
	output logic        q_valid,
	input  logic        q_pop
);

	ph_item_t          entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;
	logic              push;
	logic              do_pop;
	ph_item_t          new_item;

	assign item.ready = (fill_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign q_valid    = (fill_q != '0);
	assign q_head     = entries_q[rd_ptr_q];
	assign do_pop     = q_pop && q_valid;

	always_comb begin
		push = 1'b0;
		if (item.valid && item.ready) begin
			push = item.opcode inside {OP_COUNT, OP_READ, OP_READ_CLEAR};
		end
		new_item.op       = ph_op_t'(item.opcode);
		new_item.value    = item.value;
		new_item.in_range = (32'(item.value) < 32'(BIN_COUNT));
		new_item.addr     = BIN_W'(32'(item.value));
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			fill_q <= fill_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
		end
	end

endmodule

FILE: rtl/ph_back.sv
// Back end: bin memory, read-modify-write sequencer and result register.
module ph_back import ph_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ph_item_t    q_head,
	input  logic        q_valid,
	output logic        q_pop,
	ph_out_if.source    result
);

	logic [COUNT_BITS-1:0] mem_q [BIN_COUNT];
	logic [BIN_COUNT-1:0]  vld_q;
	ph_item_t              cur_q;
	logic [COUNT_BITS-1:0] rd_data_q;
	logic                  rd_vld_q;
	ph_bk_state_t          state_q;
	ph_bk_state_t          state_nxt;
	logic                  out_vld_q;
	logic [VALUE_W-1:0]    out_idx_q;
	logic [OUT_W-1:0]      out_cnt_q;
	logic                  out_free;
	logic                  done;
	logic                  wr_en;
	logic [COUNT_BITS-1:0] wr_data;
	logic                  load_out;
	logic [COUNT_BITS-1:0] cnt_now;

	assign result.valid     = out_vld_q;
	assign result.bin_index = out_idx_q;
	assign result.bin_count = out_cnt_q;
	assign out_free         = !out_vld_q || result.ready;
	assign cnt_now          = (rd_vld_q && cur_q.in_range) ? rd_data_q : '0;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					state_nxt = BK_APPLY;
				end
			end
			BK_APPLY: begin
				if (done) begin
					state_nxt = BK_IDLE;
				end
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		done     = 1'b0;
		wr_en    = 1'b0;
		wr_data  = '0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: begin
				q_pop = q_valid;
			end
			BK_APPLY: begin
				case (cur_q.op)
					OP_COUNT: begin
						done    = 1'b1;
						wr_en   = cur_q.in_range && (cnt_now != COUNT_MAX);
						wr_data = cnt_now + COUNT_BITS'(1);
					end
					OP_READ: begin
						done     = out_free;
						load_out = out_free;
					end
					OP_READ_CLEAR: begin
						done     = out_free;
						load_out = out_free;
						wr_en    = out_free && cur_q.in_range;
						wr_data  = '0;
					end
					default: done = 1'b1;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[cur_q.addr] <= wr_data;
		end
		if (q_pop) begin
			rd_data_q <= mem_q[q_head.addr];
			rd_vld_q  <= vld_q[q_head.addr];
			cur_q     <= q_head;
		end
		if (load_out) begin
			out_idx_q <= cur_q.value;
			out_cnt_q <= ph_out_sat(cnt_now);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (wr_en) begin
				vld_q[cur_q.addr] <= 1'b1;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/pixel_histogram.sv
// Pixel histogram top level: 256 saturating 24-bit bins behind item and result channels.
//
// Channel item carries an opcode and an 8-bit value: count pixel (add one to the
// bin, saturating), read bin, or read bin and clear it. Unused opcodes are taken
// and dropped. Channel result returns bin_index and bin_count, one per read.
// Items enter a two-deep queue; the back end reads the bin of each from the bin
// memory into a register, then updates the bin and loads the result register. It
// takes no new item from the queue until that read-modify-write over the
// single-port bin memory is done. A read on an idle block passes through the
// queue, the read register and the result register before its result shows.
// Reset clears every per-bin valid flag at once, so all bins read as zero right
// after reset with no clearing pass; the result register empties.
// While the receiver stalls, the pending result holds; the back end waits on the
// next read, the queue fills and item.ready drops. Counts still drain ahead of
// the stalled read only in order, never past it.
module pixel_histogram import ph_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	ph_in_if.sink    item,
	ph_out_if.source result
);

	ph_item_t q_head;
	logic     q_valid;
	logic     q_pop;

	ph_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.q_head  (q_head),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	ph_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_head  (q_head),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule

FILE: rtl/ph_checker.sv
// Port-level checker for the pixel histogram and its bind.
`include "pixel_histogram_assert.svh"

module ph_checker import ph_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input logic [OP_W-1:0]    item_opcode,
	input logic               result_valid,
	input logic               result_ready,
	input logic [VALUE_W-1:0] result_index,
	input logic [OUT_W-1:0]   result_count
);

	localparam int         PEND_W   = 3;
	localparam logic [2:0] MAX_PEND = PEND_W'(QUEUE_DEPTH + 2);

	logic [PEND_W-1:0] pend_q;
	logic              rd_in;
	logic              rd_out;

	assign rd_in  = item_valid && item_ready &&
		((item_opcode == OP_READ) || (item_opcode == OP_READ_CLEAR));
	assign rd_out = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + PEND_W'(rd_in) - PEND_W'(rd_out);
		end
	end

	`PH_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && !result_ready,
		result_valid && $stable(result_index) && $stable(result_count),
		"stalled result changed")
	`PH_ASSERT_IMP(a_no_orphan, clk, arst_n, result_valid, pend_q != '0,
		"result without pending read")
	`PH_ASSERT_IMP(a_pend_bound, clk, arst_n, 1'b1, pend_q <= MAX_PEND,
		"too many reads in flight")

endmodule

bind pixel_histogram ph_checker u_ph_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_opcode  (item.opcode),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_index (result.bin_index),
	.result_count (result.bin_count)
);

FILE: tb/pixel_histogram_test.sv
// Self-checking testbench for the pixel histogram: predicted bins matched per read.
`timescale 1ns / 100ps

module pixel_histogram_test;
	import ph_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 720;
	localparam int IDLE_PCT     = 19;
	localparam int CALM_FROM    = 420;
	localparam int CALM_TO      = 560;
	localparam int STALL_AT     = 300;
	localparam int STALL_CYCLES = 250;
	localparam int SETTLE       = 16;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct {
		logic [OP_W-1:0]    opcode;
		logic [VALUE_W-1:0] value;
		bit                 drain_first;
	} pixel_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] bin_index;
		logic [OUT_W-1:0]   bin_count;
	} bin_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ph_in_if  item_ch ();
	ph_out_if result_ch ();

	pixel_histogram uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	logic [COUNT_BITS-1:0] bin_tally [BIN_COUNT];
	pixel_item_t           pixel_items [$];
	bin_report_t           expected_reads [$];
	int                    sent_items = 0;
	int                    accepted_items = 0;
	int                    reads_waiting = 0;
	int                    fail_count = 0;
	int                    cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit calm_span(input int n);
		return n >= CALM_FROM && n < CALM_TO;
	endfunction

	// Apply one item to the predicted bins; return 1 when it yields a read result.
	function automatic bit tally_pixel_op(input logic [OP_W-1:0] op,
			input logic [VALUE_W-1:0] v, output bin_report_t rpt);
		bit                    in_range;
		logic [COUNT_BITS-1:0] cnt;
		logic [63:0]           wide;
		logic [63:0]           out_top;
		in_range = int'(v) < BIN_COUNT;
		out_top = (64'd1 << OUT_W) - 64'd1;
		rpt = '0;
		if (op == OP_COUNT) begin
			if (in_range && bin_tally[v] != COUNT_MAX)
				bin_tally[v] = bin_tally[v] + 1'b1;
			return 1'b0;
		end
		if (op != OP_READ && op != OP_READ_CLEAR)
			return 1'b0;
		cnt = in_range ? bin_tally[v] : '0;
		wide = 64'(cnt);
		if (wide > out_top)
			wide = out_top;
		rpt.bin_index = v;
		rpt.bin_count = wide[OUT_W-1:0];
		if (op == OP_READ_CLEAR && in_range)
			bin_tally[v] = '0;
		return 1'b1;
	endfunction

	task automatic queue_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] v,
			input bit drain);
		pixel_item_t it;
		it.opcode = op;
		it.value = v;
		it.drain_first = drain;
		pixel_items.push_back(it);
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_items
		pixel_item_t nxt;
		bit          hold;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.opcode <= OP_COUNT;
			item_ch.value <= '0;
		end else if (!item_ch.valid || item_ch.ready) begin
			hold = pixel_items.size() == 0;
			if (!hold && pixel_items[0].drain_first)
				hold = accepted_items != sent_items || reads_waiting != 0;
			if (!hold && !calm_span(sent_items))
				hold = $urandom_range(0, 99) < IDLE_PCT;
			if (hold) begin
				item_ch.valid <= 1'b0;
			end else begin
				nxt = pixel_items.pop_front();
				item_ch.valid <= 1'b1;
				item_ch.opcode <= nxt.opcode;
				item_ch.value <= nxt.value;
				sent_items++;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_results
		bin_report_t got;
		bin_report_t want;
		bin_report_t rpt;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got.bin_index = result_ch.bin_index;
				got.bin_count = result_ch.bin_count;
				if (expected_reads.size() == 0) begin
					$error("unexpected result: bin_index %0d, bin_count %0d",
						got.bin_index, got.bin_count);
					fail_count++;
				end else begin
					want = expected_reads.pop_front();
					if (got.bin_index !== want.bin_index) begin
						$error("bin_index mismatch: expected %0d, actual %0d",
							want.bin_index, got.bin_index);
						fail_count++;
					end
					if (got.bin_count !== want.bin_count) begin
						$error("bin_count mismatch: expected %0d, actual %0d",
							want.bin_count, got.bin_count);
						fail_count++;
					end
				end
			end
			if (item_ch.valid && item_ch.ready) begin
				if (tally_pixel_op(item_ch.opcode, item_ch.value, rpt))
					expected_reads.push_back(rpt);
				accepted_items <= accepted_items + 1;
			end
			reads_waiting <= expected_reads.size();
		end
	end

	always @(posedge clk or negedge arst_n) begin : pace_results
		int stall_left;
		bit stall_done;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left = 0;
			stall_done = 1'b0;
		end else begin
			if (!stall_done && accepted_items == STALL_AT) begin
				stall_left = STALL_CYCLES;
				stall_done = 1'b1;
			end
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else if (calm_span(accepted_items)) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= $urandom_range(0, 99) >= IDLE_PCT;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		logic [VALUE_W-1:0] hot [8];
		logic [VALUE_W-1:0] burst_bin;
		logic [VALUE_W-1:0] v;
		logic [OP_W-1:0]    op;
		int                 burst_len;
		int                 r;
		int                 n;
		for (int i = 0; i < BIN_COUNT; i++)
			bin_tally[i] = '0;

		queue_item(OP_READ, 8'd0, 1'b0);
		queue_item(OP_READ, 8'd255, 1'b0);
		queue_item(OP_COUNT, 8'd0, 1'b0);
		queue_item(OP_COUNT, 8'd255, 1'b0);
		queue_item(OP_COUNT, 8'd255, 1'b0);
		queue_item(OP_READ, 8'd0, 1'b0);
		queue_item(OP_READ, 8'd255, 1'b0);
		queue_item(OP_READ_CLEAR, 8'd255, 1'b0);
		queue_item(OP_READ, 8'd255, 1'b0);
		queue_item(OP_SPARE, 8'd0, 1'b0);
		queue_item(OP_SPARE, 8'd255, 1'b0);
		queue_item(OP_READ, 8'd0, 1'b0);
		queue_item(OP_COUNT, 8'h55, 1'b0);
		queue_item(OP_COUNT, 8'hAA, 1'b0);
		queue_item(OP_COUNT, 8'hAA, 1'b0);
		queue_item(OP_READ, 8'h55, 1'b0);
		queue_item(OP_READ_CLEAR, 8'hAA, 1'b0);
		queue_item(OP_READ_CLEAR, 8'hAA, 1'b0);
		queue_item(OP_COUNT, 8'hAA, 1'b0);
		queue_item(OP_READ, 8'hAA, 1'b0);
		queue_item(OP_READ_CLEAR, 8'h55, 1'b0);
		queue_item(OP_READ, 8'h55, 1'b1);

		// Favor eight hot bins so counts grow; bursts on one bin stress back-to-back read-modify-write.
		for (int i = 0; i < 8; i++)
			hot[i] = 8'($urandom_range(0, 255));
		n = 0;
		while (n < RANDOM_ITEMS) begin
			burst_bin = ($urandom_range(0, 99) < 70) ? hot[3'($urandom_range(0, 7))]
				: 8'($urandom_range(0, 255));
			burst_len = $urandom_range(1, 8);
			for (int k = 0; k < burst_len; k++) begin
				r = $urandom_range(0, 99);
				op = (r < 60) ? OP_COUNT : (r < 80) ? OP_READ
					: (r < 95) ? OP_READ_CLEAR : OP_SPARE;
				v = ($urandom_range(0, 99) < 80) ? burst_bin : 8'($urandom_range(0, 255));
				queue_item(op, v, n == 500 || n == 650);
				if (op != OP_SPARE)
					n++;
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (pixel_items.size() != 0 || item_ch.valid || reads_waiting != 0);
		repeat (SETTLE) @(negedge clk);

		if (expected_reads.size() != 0) begin
			$error("%0d read results never arrived", expected_reads.size());
			fail_count += expected_reads.size();
		end
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
